// File: sv/p2ca_pkg.sv
`default_nettype none

package p2ca_pkg;

  // Fixed field widths of the request and result channels.
  localparam int SIZE_LOG_W  = 4;
  localparam int FIELD_W     = 12;
  localparam int PIECE_LOG_W = 4;
  // Offsets inside a fresh region reach 2^16, so 17 bits hold them.
  localparam int REM_W       = 17;
  localparam int LOW_W       = 16;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_LIST   = 2'd0,
    STAT_FRESH  = 2'd1,
    STAT_FREED  = 2'd2,
    STAT_REJECT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_POP,
    ST_CARVE,
    ST_DONE
  } state_t;

  // One step of carving a fresh region: either the granted piece or a
  // piece to push, with the log2 of its size.
  typedef struct packed {
    logic                   grant;
    logic [PIECE_LOG_W-1:0] piece_log;
  } carve_step_t;

endpackage

`default_nettype wire

// File: sv/p2ca_link_ram.sv
`default_nettype none

module p2ca_link_ram #(
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [ADDR_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [ADDR_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [ADDR_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] rd_data_r;

  // Next-link table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: sv/p2ca_carve_step.sv
`default_nettype none

module p2ca_carve_step (
  input  wire logic [p2ca_pkg::LOW_W-1:0]      c_low,
  input  wire logic [p2ca_pkg::REM_W-1:0]      remain,
  input  wire logic [p2ca_pkg::SIZE_LOG_W-1:0] size_log,
  input  wire logic                            found,
  output p2ca_pkg::carve_step_t                step
);

  import p2ca_pkg::*;

  // Number of trailing zero bits, sixteen for a zero value.
  function automatic logic [4:0] trail_zeros(input logic [LOW_W-1:0] v);
    logic [4:0] n;
    n = 5'(LOW_W);
    for (int i = LOW_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = 5'(i);
      end
    end
    return n;
  endfunction

  // Position of the highest set bit.
  function automatic logic [4:0] top_bit(input logic [REM_W-1:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < REM_W; i++) begin
      if (v[i]) begin
        n = 5'(i);
      end
    end
    return n;
  endfunction

  logic [LOW_W-1:0] align_mask;
  logic [4:0]       tz;
  logic [4:0]       fit;
  logic [4:0]       best;

  // The first piece aligned to the class size is the grant; every other
  // piece is the largest aligned power of two that still fits.
  always_comb begin
    align_mask = (LOW_W'(1) << size_log) - LOW_W'(1);
    tz         = trail_zeros(c_low);
    fit        = top_bit(remain);
    best       = (tz < fit) ? tz : fit;
    step.grant = !found && ((c_low & align_mask) == '0);
    if (step.grant) begin
      step.piece_log = size_log;
    end else begin
      step.piece_log = PIECE_LOG_W'(best);
    end
  end

endmodule

`default_nettype wire

// File: sv/p2ca_ctrl.sv
`default_nettype none

module p2ca_ctrl #(
  parameter int CHUNK_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire p2ca_pkg::op_t                   req_op,
  input  wire logic [p2ca_pkg::SIZE_LOG_W-1:0] req_size_log,
  input  wire logic [p2ca_pkg::FIELD_W-1:0]    req_chunk,
  input  wire logic [p2ca_pkg::FIELD_W-1:0]    req_fresh_base,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output p2ca_pkg::status_t                    res_status,
  output logic [p2ca_pkg::FIELD_W-1:0]         res_granted
);

  import p2ca_pkg::*;

  localparam int CB    = CHUNK_BITS;
  localparam int CLW   = (CB > 1) ? $clog2(CB) : 1;
  // Wide enough for a region end of up to 2^CB or base plus 2^16.
  localparam int EW    = ((CB > REM_W) ? CB : REM_W) + 1;
  localparam logic [EW-1:0] TABLE_END = EW'(1) << CB;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [SIZE_LOG_W-1:0] k_r, k_nxt;
  logic [FIELD_W-1:0]    chunk_r, chunk_nxt;
  logic [FIELD_W-1:0]    base_r, base_nxt;
  logic [EW-1:0]     c_r, c_nxt;
  logic [EW-1:0]     end_r, end_nxt;
  logic              found_r, found_nxt;
  logic [CB-1:0]     h_r, h_nxt;
  status_t           stat_r, stat_nxt;
  logic [FIELD_W-1:0]    grant_r, grant_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [FIELD_W-1:0]    out_granted_r, out_granted_nxt;

  logic [CB-1:0]     heads_r [CB];
  logic              heads_we;
  logic [CLW-1:0]    heads_widx;
  logic [CB-1:0]     heads_wdata;
  logic [CLW-1:0]    heads_ridx;
  logic [CB-1:0]     head_rd;

  logic              link_we;
  logic [CB-1:0]     link_waddr;
  logic [CB-1:0]     link_wdata;
  logic              link_re;
  logic [CB-1:0]     link_rdata;

  carve_step_t       step;
  logic [EW-1:0]     remain_w;
  logic              out_free;
  logic              k_ok;
  logic              free_ok;
  logic              carve_ok;
  logic [EW-1:0]     region_end;

  assign req_ready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || res_ready;

  // Request checks made while deciding.
  always_comb begin
    k_ok       = (32'(k_r) < CB);
    free_ok    = (chunk_r != '0) && (EW'(chunk_r) < TABLE_END);
    region_end = EW'(base_r) + (EW'(2) << k_r);
    carve_ok   = (base_r != '0) && (region_end <= TABLE_END);
  end

  // One head read per cycle: the piece class while carving, else the request class.
  assign heads_ridx = (state_r == ST_CARVE) ? CLW'(step.piece_log) : CLW'(k_r);
  assign head_rd    = heads_r[heads_ridx];

  assign remain_w = end_r - c_r;

  p2ca_carve_step u_carve_step (
    .c_low    (c_r[LOW_W-1:0]),
    .remain   (remain_w[REM_W-1:0]),
    .size_log (k_r),
    .found    (found_r),
    .step     (step)
  );

  p2ca_link_ram #(
    .ADDR_W (CB)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (link_wdata),
    .rd_en   (link_re),
    .rd_addr (head_rd),
    .rd_data (link_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (!k_ok || op_r == OP_FREE) begin
          state_nxt = ST_DONE;
        end else if (head_rd != '0) begin
          state_nxt = ST_POP;
        end else if (carve_ok) begin
          state_nxt = ST_CARVE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_POP: begin
        state_nxt = ST_DONE;
      end
      ST_CARVE: begin
        if (c_r >= end_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and memory controls for each state.
  always_comb begin
    op_nxt          = op_r;
    k_nxt           = k_r;
    chunk_nxt       = chunk_r;
    base_nxt        = base_r;
    c_nxt           = c_r;
    end_nxt         = end_r;
    found_nxt       = found_r;
    h_nxt           = h_r;
    stat_nxt        = stat_r;
    grant_nxt       = grant_r;
    out_valid_nxt   = out_valid_r && !res_ready;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    heads_we        = 1'b0;
    heads_widx      = CLW'(k_r);
    heads_wdata     = head_rd;
    link_we         = 1'b0;
    link_waddr      = c_r[CB-1:0];
    link_wdata      = head_rd;
    link_re         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          op_nxt    = req_op;
          k_nxt     = req_size_log;
          chunk_nxt = req_chunk;
          base_nxt  = req_fresh_base;
        end
      end
      ST_DECIDE: begin
        stat_nxt  = STAT_REJECT;
        grant_nxt = '0;
        priority if (!k_ok) begin
          stat_nxt = STAT_REJECT;
        end else if (op_r == OP_FREE) begin
          if (free_ok) begin
            link_we     = 1'b1;
            link_waddr  = CB'(chunk_r);
            heads_we    = 1'b1;
            heads_wdata = CB'(chunk_r);
            stat_nxt    = STAT_FREED;
          end
        end else if (head_rd != '0) begin
          link_re = 1'b1;
          h_nxt   = head_rd;
        end else if (carve_ok) begin
          c_nxt     = EW'(base_r);
          end_nxt   = region_end;
          found_nxt = 1'b0;
        end else begin
          stat_nxt = STAT_REJECT;
        end
      end
      ST_POP: begin
        heads_we    = 1'b1;
        heads_wdata = link_rdata;
        stat_nxt    = STAT_LIST;
        grant_nxt   = FIELD_W'(h_r);
      end
      ST_CARVE: begin
        if (c_r < end_r) begin
          c_nxt = c_r + (EW'(1) << step.piece_log);
          if (step.grant) begin
            found_nxt = 1'b1;
            grant_nxt = c_r[FIELD_W-1:0];
          end else begin
            link_we     = 1'b1;
            heads_we    = 1'b1;
            heads_widx  = CLW'(step.piece_log);
            heads_wdata = c_r[CB-1:0];
          end
        end else begin
          stat_nxt = STAT_FRESH;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = stat_r;
          out_granted_nxt = grant_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state and list heads, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      for (int i = 0; i < CB; i++) begin
        heads_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      if (heads_we) begin
        heads_r[heads_widx] <= heads_wdata;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    k_r           <= k_nxt;
    chunk_r       <= chunk_nxt;
    base_r        <= base_nxt;
    c_r           <= c_nxt;
    end_r         <= end_nxt;
    h_r           <= h_nxt;
    stat_r        <= stat_nxt;
    grant_r       <= grant_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
  end

  assign res_valid   = out_valid_r;
  assign res_status  = out_status_r;
  assign res_granted = out_granted_r;

  // Chunk 0 terminates every list, so no link for it is ever written.
  a_no_link_zero: assert property (@(posedge clk) disable iff (!rst_n)
    link_we |-> (link_waddr != '0))
    else $error("link written for chunk zero");

  // A list head only becomes empty when its last block is popped.
  a_head_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (heads_we && heads_wdata == '0) |-> (state_r == ST_POP))
    else $error("list head cleared outside a pop");

  // A finished carve has always granted its aligned piece.
  a_carve_granted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CARVE && c_r >= end_r) |-> found_r)
    else $error("fresh region finished without a grant");

  // A pop only follows the decision that read a non-empty head.
  a_pop_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> ($past(state_r) == ST_DECIDE))
    else $error("pop entered out of order");

  // An out-of-range class always ends in a rejection.
  a_class_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && !k_ok) |=> (stat_r == STAT_REJECT))
    else $error("out-of-range class not rejected");

endmodule

`default_nettype wire

// File: sv/pow2_aligned_chunk_allocator_top.sv
`default_nettype none

// Power-of-two chunk allocator with one LIFO free list per size class. The
// lists are linked through a next-link memory of 2^CHUNK_BITS entries that is
// not cleared; only the list heads reset. A request is accepted only while
// the sequencer is idle, and its result then waits in an output register, so
// the next request can be taken before the result is collected. The result of
// a free or a rejected request is worked out in the decide and done states,
// that of a pop from a non-empty list also passes the pop state (for the
// registered link-memory read), and that of an allocation carved from a
// fresh region also passes the carve state, which pushes the pieces of the
// region, at most 2k+1 pieces for class k (two for class 0), since the single
// write port of the link memory takes one pushed piece per cycle. The
// sequencer is idle again in the cycle the result is presented; a result
// that is not collected holds the following request in its last step.
module pow2_aligned_chunk_allocator_top #(
  parameter int CHUNK_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [3:0] size_log, [15:4] chunk, [27:16] fresh_base, [31:28] zero
  input  wire logic [31:0] in_tdata,
  // [0] operation
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [11:0] granted_chunk, [15:12] zero
  output logic [15:0]      out_tdata,
  // [1:0] status
  output logic [1:0]       out_tuser
);

  import p2ca_pkg::*;

  op_t                 req_op;
  status_t             res_status;
  logic [FIELD_W-1:0]  res_granted;

  // Unpack the request fields.
  assign req_op = op_t'(in_tuser[0]);

  p2ca_ctrl #(
    .CHUNK_BITS (CHUNK_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (in_tvalid),
    .req_ready      (in_tready),
    .req_op         (req_op),
    .req_size_log   (in_tdata[3:0]),
    .req_chunk      (in_tdata[15:4]),
    .req_fresh_base (in_tdata[27:16]),
    .res_valid      (out_tvalid),
    .res_ready      (out_tready),
    .res_status     (res_status),
    .res_granted    (res_granted)
  );

  // Pack the result fields.
  assign out_tdata = {4'b0000, res_granted};
  assign out_tuser = res_status;

endmodule

`default_nettype wire

// File: test/tb_pow2_aligned_chunk_allocator_top.sv
`timescale 1ns / 1ps

module tb_pow2_aligned_chunk_allocator_top;
  import p2ca_pkg::*;

  localparam int CLASS_COUNT     = 12;
  localparam int TABLE_DEPTH     = 1 << CLASS_COUNT;
  localparam int RANDOM_REQUESTS = 1830;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 40;
  localparam int FIRST_FRESH     = 64;
  localparam longint CYCLE_LIMIT = 1000000;

  // What one request should produce.
  typedef struct packed {
    status_t     status;
    logic [11:0] chunk;
  } grant_t;

  // One row of the directed table. Rows marked hand_checked carry their own
  // answer; the others are left to the predictor.
  typedef struct packed {
    op_t         op;
    logic [3:0]  size_log;
    logic [11:0] chunk;
    logic [11:0] base;
    logic        hand_checked;
    status_t     want_status;
    logic [11:0] want_chunk;
  } request_row_t;

  localparam int DIRECTED_ROWS = 21;

  request_row_t directed_rows [DIRECTED_ROWS] = '{
    // Rejections while every list is still empty.
    '{OP_ALLOC, 4'd0,  12'd77,   12'd0,    1'b1, STAT_REJECT, 12'd0},
    '{OP_ALLOC, 4'd12, 12'd0,    12'd100,  1'b1, STAT_REJECT, 12'd0},
    '{OP_ALLOC, 4'd15, 12'hfff,  12'hfff,  1'b1, STAT_REJECT, 12'd0},
    '{OP_FREE,  4'd3,  12'd0,    12'd5,    1'b1, STAT_REJECT, 12'd0},
    '{OP_FREE,  4'd15, 12'hfff,  12'd0,    1'b1, STAT_REJECT, 12'd0},
    '{OP_ALLOC, 4'd10, 12'd0,    12'd2049, 1'b1, STAT_REJECT, 12'd0},
    '{OP_ALLOC, 4'd11, 12'd0,    12'd1,    1'b1, STAT_REJECT, 12'd0},
    // Smallest class at the very top of the table, then its leftover piece.
    '{OP_ALLOC, 4'd0,  12'd0,    12'd4094, 1'b1, STAT_FRESH,  12'd4094},
    '{OP_ALLOC, 4'd0,  12'hfff,  12'd0,    1'b1, STAT_LIST,   12'd4095},
    // Largest region that still fits, then its other half.
    '{OP_ALLOC, 4'd10, 12'd0,    12'd2048, 1'b1, STAT_FRESH,  12'd2048},
    '{OP_ALLOC, 4'd10, 12'd0,    12'd0,    1'b1, STAT_LIST,   12'd3072},
    '{OP_FREE,  4'd5,  12'd4095, 12'd4095, 1'b1, STAT_FREED,  12'd0},
    '{OP_ALLOC, 4'd5,  12'd0,    12'd7,    1'b1, STAT_LIST,   12'd4095},
    // Misaligned region: pieces of several classes land on their lists.
    '{OP_ALLOC, 4'd3,  12'd0,    12'd3,    1'b0, STAT_REJECT, 12'd0},
    '{OP_ALLOC, 4'd1,  12'd0,    12'd100,  1'b0, STAT_REJECT, 12'd0},
    '{OP_ALLOC, 4'd2,  12'd0,    12'd100,  1'b0, STAT_REJECT, 12'd0},
    '{OP_ALLOC, 4'd0,  12'd0,    12'd100,  1'b0, STAT_REJECT, 12'd0},
    // Misaligned and repeated free, kept to the top class, which can
    // never carve and so loses nothing by a looped list.
    '{OP_FREE,  4'd11, 12'd1,    12'd0,    1'b1, STAT_FREED,  12'd0},
    '{OP_FREE,  4'd11, 12'd1,    12'd0,    1'b1, STAT_FREED,  12'd0},
    '{OP_ALLOC, 4'd11, 12'd0,    12'd0,    1'b1, STAT_LIST,   12'd1},
    '{OP_ALLOC, 4'd4,  12'd0,    12'd1,    1'b0, STAT_REJECT, 12'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  // Predictor state: list heads per class and the link table.
  logic [11:0] free_head [CLASS_COUNT] = '{default: '0};
  logic [11:0] next_link [TABLE_DEPTH] = '{default: '0};

  grant_t      pending_grants [$];
  logic [11:0] held_chunks [$];
  logic [3:0]  held_classes [$];

  int     error_count = 0;
  int     request_count = 0;
  int     drain_count = 0;
  int     status_seen [4] = '{default: 0};
  int     burst_left = 0;
  bit     hold_off_req = 1'b0;
  bit     hold_off_done = 1'b0;
  longint cycle_count = 0;

  pow2_aligned_chunk_allocator_top #(
    .CHUNK_BITS(CLASS_COUNT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Push a block onto the free list of its class.
  function automatic void push_free(logic [11:0] chunk, int cls);
    next_link[chunk] = free_head[cls];
    free_head[cls] = chunk;
  endfunction

  // Work out the result of one request and update the predicted lists.
  function automatic grant_t predict_grant(op_t op, logic [3:0] size_log,
                                           logic [11:0] chunk, logic [11:0] base);
    grant_t r;
    int     piece;
    int     stop;
    int     c;
    int     lz;
    bit     found;
    r.status = STAT_REJECT;
    r.chunk  = '0;
    if (int'(size_log) < CLASS_COUNT) begin
      if (op == OP_FREE) begin
        // A 12-bit chunk always lies inside the table; only zero is refused.
        if (chunk != '0) begin
          push_free(chunk, int'(size_log));
          r.status = STAT_FREED;
        end
      end else if (free_head[size_log] != '0) begin
        r.chunk = free_head[size_log];
        free_head[size_log] = next_link[r.chunk];
        r.status = STAT_LIST;
      end else begin
        piece = 1 << size_log;
        stop  = int'(base) + 2 * piece;
        if (base != '0 && stop <= TABLE_DEPTH) begin
          c     = int'(base);
          found = 1'b0;
          // Grant the first aligned piece; every other stretch goes to the
          // list of the largest aligned power of two that fits.
          while (c < stop) begin
            if (!found && (c & (piece - 1)) == 0) begin
              r.chunk = 12'(c);
              found   = 1'b1;
              c      += piece;
            end else begin
              lz = 0;
              while (lz < 31 && ((c >> lz) & 1) == 0) lz++;
              while (lz > 0 && c + (1 << lz) > stop) lz--;
              if (lz < CLASS_COUNT) push_free(12'(c), lz);
              c += 1 << lz;
            end
          end
          r.status = STAT_FRESH;
        end
      end
    end
    return r;
  endfunction

  // Offer one request, wait for it to be taken and record its outcome.
  task automatic send_request(input op_t op, input logic [3:0] size_log,
                              input logic [11:0] chunk, input logic [11:0] base,
                              input logic hand_checked, input status_t want_status,
                              input logic [11:0] want_chunk, output status_t got);
    grant_t g;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, base, chunk, size_log};
    do @(posedge clk); while (!in_tready);
    g = predict_grant(op, size_log, chunk, base);
    got = g.status;
    if (op == OP_ALLOC && (g.status == STAT_LIST || g.status == STAT_FRESH)) begin
      held_chunks.push_back(g.chunk);
      held_classes.push_back(size_log);
    end
    if (hand_checked) begin
      g.status = want_status;
      g.chunk  = want_chunk;
    end
    pending_grants.push_back(g);
    request_count++;
  endtask

  // Sender pacing: bursts of random length with random gaps between them.
  task automatic pace_sender();
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // Stimulus.
  initial begin
    status_t     got;
    int unsigned cls;
    int unsigned span;
    int unsigned base;
    int unsigned idx;
    int unsigned choice;
    int unsigned fresh_next;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      pace_sender();
      send_request(directed_rows[i].op, directed_rows[i].size_log,
                   directed_rows[i].chunk, directed_rows[i].base,
                   directed_rows[i].hand_checked, directed_rows[i].want_status,
                   directed_rows[i].want_chunk, got);
    end

    fresh_next = FIRST_FRESH;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 700) begin
        // Keep offering requests while the receiver holds off.
        hold_off_req = 1'b1;
        burst_left   = 60;
      end
      if (n % 450 == 449) begin
        // Let the block empty out completely before going on.
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_grants.size() != 0);
        drain_count++;
      end else begin
        pace_sender();
      end

      choice = $urandom_range(0, 99);
      if (choice < 48 || (choice < 88 && held_chunks.size() == 0)) begin
        // Allocation, with its fresh base in untouched space above the frontier.
        choice = $urandom_range(0, 99);
        cls  = (choice < 80) ? $urandom_range(0, 5) :
               (choice < 96) ? $urandom_range(6, 8) : $urandom_range(9, 10);
        span = 2 << cls;
        base = fresh_next + $urandom_range(0, 3);
        // Once the table is used up, regions overlap earlier ones.
        if (base + span > TABLE_DEPTH) base = $urandom_range(1, TABLE_DEPTH - span);
        send_request(OP_ALLOC, 4'(cls), 12'($urandom_range(0, 4095)), 12'(base),
                     1'b0, STAT_REJECT, 12'd0, got);
        if (got == STAT_FRESH) fresh_next = base + span;
      end else if (choice < 88) begin
        // Return a block that is currently handed out.
        idx = $urandom_range(0, held_chunks.size() - 1);
        send_request(OP_FREE, held_classes[idx], held_chunks[idx],
                     12'($urandom_range(0, 4095)), 1'b0, STAT_REJECT, 12'd0, got);
        held_chunks.delete(idx);
        held_classes.delete(idx);
      end else begin
        // Requests the block must refuse, or that can only pop.
        cls = $urandom_range(0, 10);
        case ($urandom_range(0, 5))
          0: send_request(OP_FREE, 4'($urandom_range(12, 15)),
                          12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                          1'b0, STAT_REJECT, 12'd0, got);
          1: send_request(OP_FREE, 4'($urandom_range(0, 15)), 12'd0,
                          12'($urandom_range(0, 4095)), 1'b0, STAT_REJECT, 12'd0, got);
          2: send_request(OP_ALLOC, 4'($urandom_range(12, 15)),
                          12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                          1'b0, STAT_REJECT, 12'd0, got);
          3: send_request(OP_ALLOC, 4'(cls), 12'($urandom_range(0, 4095)),
                          12'($urandom_range(TABLE_DEPTH - (2 << cls) + 1, 4095)),
                          1'b0, STAT_REJECT, 12'd0, got);
          4: send_request(OP_ALLOC, 4'(cls), 12'($urandom_range(0, 4095)), 12'd0,
                          1'b0, STAT_REJECT, 12'd0, got);
          default: send_request(OP_ALLOC, 4'd11, 12'($urandom_range(0, 4095)),
                                12'($urandom_range(0, 4095)), 1'b0, STAT_REJECT,
                                12'd0, got);
        endcase
      end
    end
    in_tvalid <= 1'b0;

    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d list pops, %0d fresh carves, %0d frees, %0d refusals.",
             request_count, status_seen[STAT_LIST], status_seen[STAT_FRESH],
             status_seen[STAT_FREED], status_seen[STAT_REJECT]);
    $display("Receiver held off for %0d cycles once; the block was drained %0d times.",
             HOLD_OFF_CYCLES, drain_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: changes its stall behaviour from phase to phase, with one
  // long hold-off to back the block up.
  initial begin
    int unsigned mode;
    int unsigned phase_left;
    logic [7:0]  stall_pattern;
    mode          = 0;
    phase_left    = 0;
    stall_pattern = '1;
    out_tready    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (phase_left == 0) begin
          mode          = $urandom_range(0, 3);
          phase_left    = $urandom_range(20, 150);
          stall_pattern = 8'($urandom);
        end
        phase_left--;
        stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= stall_pattern[0];
          default: out_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Result checking against the oldest outstanding request.
  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_grants.size() == 0) begin
        $error("Result with no request outstanding: status %0d, granted_chunk %0d",
               out_tuser, out_tdata[11:0]);
        error_count++;
      end else begin
        want = pending_grants.pop_front();
        if (out_tuser !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_tuser);
          error_count++;
        end
        if (out_tdata[11:0] !== want.chunk) begin
          $error("granted_chunk mismatch: expected %0d, actual %0d",
                 want.chunk, out_tdata[11:0]);
          error_count++;
        end
        status_seen[want.status]++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_grants.size());
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// File: sim.f
sv/p2ca_pkg.sv
sv/p2ca_link_ram.sv
sv/p2ca_carve_step.sv
sv/p2ca_ctrl.sv
sv/pow2_aligned_chunk_allocator_top.sv
test/tb_pow2_aligned_chunk_allocator_top.sv
